### rtl/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types, codes and sizes for the sorted list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sle_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int OCC_W    = 5;

	localparam logic [2:0] OP_INSERT = 3'd0;
	localparam logic [2:0] OP_SEARCH = 3'd1;
	localparam logic [2:0] OP_DELETE = 3'd2;
	localparam logic [2:0] OP_POP    = 3'd3;
	localparam logic [2:0] OP_DUMP   = 3'd4;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_EMPTY     = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	typedef struct packed {
		logic [2:0]         opcode;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic               found;
		logic signed [31:0] element;
		logic [OCC_W-1:0]   occupancy;
		logic               last;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic exec;
		logic dump;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic more_after_exec;
		logic last_dump;
	} sts_t;

endpackage

`default_nettype wire

### rtl/sorted_list_engine_unit.sv
// ----------------------------------------------------------------------------
// sorted_list_engine_unit
// Bounded ascending multiset of signed 32-bit values with insert, search,
// delete, pop-smallest and dump operations.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req) carries one word: opcode and
//   value. rsp channel (rsp_valid / rsp_stall / rsp) returns result words.
//   Each request yields one result word with last set, except a dump of a
//   non-empty store, which yields one word per stored value in ascending
//   order with last on the final one.
//   A word is captured when accepted and executed once the response
//   register is free; execution also loads the response register.
//   The store updates all entries in parallel through a row of compare
//   cells; a dump reads one entry per cycle unless the response stalls.
//   req_stall is high while a word is being executed or dumped. A stalled
//   response holds; the next request may still be accepted, and it waits
//   in the execute step until the response register is free.
//   Reset empties the store (count cleared); no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_engine_unit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire sle_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output sle_pkg::rsp_t      rsp
);

	sle_pkg::cmd_t cmd;
	sle_pkg::sts_t sts;

	sle_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	sle_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

### rtl/sle_ctrl.sv
// ----------------------------------------------------------------------------
// sle_ctrl
// Sequencer: accepts a word, runs the operation, steps through a dump and
// owns the response valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output sle_pkg::cmd_t      cmd,
	input  wire sle_pkg::sts_t sts
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_DUMP = 2'd2;

	logic [1:0] state_q, state_d;
	logic       rsp_valid_q;
	logic       out_free;

	assign out_free    = !rsp_valid_q || !rsp_stall;
	assign req_stall   = (state_q != S_IDLE);
	assign rsp_valid   = rsp_valid_q;

	assign cmd.capture = (state_q == S_IDLE) && req_valid;
	assign cmd.exec    = (state_q == S_EXEC) && out_free;
	assign cmd.dump    = (state_q == S_DUMP) && out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (out_free) state_d = sts.more_after_exec ? S_DUMP : S_IDLE;
			end
			S_DUMP: begin
				if (out_free && sts.last_dump) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec || cmd.dump) rsp_valid_q <= 1'b1;
			else if (!rsp_stall)      rsp_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

### rtl/sle_datapath.sv
// ----------------------------------------------------------------------------
// sle_datapath
// Ordered store as a row of compare cells; every entry updates in
// parallel for insert, delete and pop. Holds the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_datapath (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire sle_pkg::req_t req,
	input  wire sle_pkg::cmd_t cmd,
	output sle_pkg::sts_t      sts,
	output sle_pkg::rsp_t      rsp
);

	localparam int CAP   = sle_pkg::CAPACITY;
	localparam int IDX_W = sle_pkg::IDX_W;
	localparam int CNT_W = sle_pkg::CNT_W;
	localparam int OCC_W = sle_pkg::OCC_W;

	logic [2:0]         op_q;
	logic signed [31:0] val_q;
	logic signed [31:0] store_q [CAP];
	logic signed [31:0] store_d [CAP];
	logic [CNT_W-1:0]   count_q, count_d;
	logic [IDX_W-1:0]   idx_q;
	sle_pkg::rsp_t      rsp_q, rsp_d;

	logic [CAP-1:0] lt, eq;
	logic           empty, full, hit;

	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_W'(CAP));
	assign hit   = |eq;

	// per-cell compares; entries at or past the count never match
	always_comb begin
		for (int i = 0; i < CAP; i++) begin
			lt[i] = (CNT_W'(i) < count_q) && (store_q[i] < val_q);
			eq[i] = (CNT_W'(i) < count_q) && (store_q[i] == val_q);
		end
	end

	assign sts.more_after_exec = (op_q == sle_pkg::OP_DUMP) && (count_q > CNT_W'(1));
	assign sts.last_dump       = (CNT_W'(idx_q) + CNT_W'(1) == count_q);

	always_comb begin
		for (int i = 0; i < CAP; i++) store_d[i] = store_q[i];
		count_d = count_q;
		rsp_d   = '0;
		rsp_d.last = 1'b1;
		if (cmd.dump) begin
			rsp_d.status  = sle_pkg::ST_OK;
			rsp_d.element = store_q[idx_q];
			rsp_d.last    = sts.last_dump;
		end else begin
			case (op_q)
				sle_pkg::OP_INSERT: begin
					if (full) begin
						rsp_d.status = sle_pkg::ST_FULL;
					end else begin
						// cells below the slot keep, the slot takes the value,
						// cells above take their lower neighbor
						store_d[0] = lt[0] ? store_q[0] : val_q;
						for (int i = 1; i < CAP; i++) begin
							if (lt[i])        store_d[i] = store_q[i];
							else if (lt[i-1]) store_d[i] = val_q;
							else              store_d[i] = store_q[i-1];
						end
						count_d = count_q + CNT_W'(1);
					end
				end
				sle_pkg::OP_SEARCH: begin
					rsp_d.status = hit ? sle_pkg::ST_OK : sle_pkg::ST_NOT_FOUND;
					rsp_d.found  = hit;
				end
				sle_pkg::OP_DELETE: begin
					if (empty) begin
						rsp_d.status = sle_pkg::ST_EMPTY;
					end else if (!hit) begin
						rsp_d.status = sle_pkg::ST_NOT_FOUND;
					end else begin
						// sorted, so the first match is the first cell not below
						for (int i = 0; i < CAP - 1; i++)
							if (!lt[i]) store_d[i] = store_q[i+1];
						count_d     = count_q - CNT_W'(1);
						rsp_d.found = 1'b1;
					end
				end
				sle_pkg::OP_POP: begin
					if (empty) begin
						rsp_d.status = sle_pkg::ST_EMPTY;
					end else begin
						for (int i = 0; i < CAP - 1; i++) store_d[i] = store_q[i+1];
						count_d       = count_q - CNT_W'(1);
						rsp_d.element = store_q[0];
					end
				end
				sle_pkg::OP_DUMP: begin
					if (empty) begin
						rsp_d.status = sle_pkg::ST_EMPTY;
					end else begin
						rsp_d.element = store_q[0];
						rsp_d.last    = (count_q == CNT_W'(1));
					end
				end
				default: rsp_d.status = sle_pkg::ST_OK;
			endcase
		end
		rsp_d.occupancy = OCC_W'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= req.opcode;
			val_q <= req.value;
		end
		if (cmd.exec) begin
			for (int i = 0; i < CAP; i++) store_q[i] <= store_d[i];
			idx_q <= IDX_W'(1);
		end else if (cmd.dump) begin
			idx_q <= idx_q + IDX_W'(1);
		end
		if (cmd.exec || cmd.dump) rsp_q <= rsp_d;
	end

	assign rsp = rsp_q;

endmodule

`default_nettype wire

### rtl/sle_checker.sv
// ----------------------------------------------------------------------------
// sle_checker
// Port-level checks for the sorted list engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_stall,
	input wire logic          rsp_valid,
	input wire logic          rsp_stall,
	input wire sle_pkg::rsp_t rsp
);

	// held response word stays put
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response word changed");

	// one word in flight at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted without going busy");

	a_full_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == sle_pkg::ST_FULL
			|-> rsp.occupancy == sle_pkg::OCC_W'(sle_pkg::CAPACITY) && rsp.last)
		else $error("full status with store not at capacity");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.found |-> rsp.status == sle_pkg::ST_OK && rsp.last
			&& rsp.element == 32'sd0)
		else $error("found flag on a bad response word");

endmodule

bind sorted_list_engine_unit sle_checker u_sle_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

`default_nettype wire

### verif/tb_sorted_list_engine_unit.sv
// ----------------------------------------------------------------------------
// tb_sorted_list_engine_unit
// Self-checking bench for the sorted list engine. A queue of request words
// feeds a clocked driver. A clocked monitor compares each result word against
// a shadow sorted store that is updated as requests are accepted. Both sides
// pause at random between words.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sorted_list_engine_unit;
	timeunit 1ns;
	timeprecision 1ps;

	// opcodes the engine ignores
	localparam logic [2:0] OP_RSVD5 = 3'd5;
	localparam logic [2:0] OP_RSVD6 = 3'd6;
	localparam logic [2:0] OP_RSVD7 = 3'd7;

	localparam int WAIT_MAX = 12;
	localparam int LIMIT    = 400000;
	localparam int ROUNDS   = 8;
	localparam int DRAIN_CT = sle_pkg::CAPACITY + 1;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_stall;
	sle_pkg::req_t req       = '0;
	logic          rsp_valid;
	logic          rsp_stall = 1'b0;
	sle_pkg::rsp_t rsp;

	// shadow of the sorted store
	logic signed [31:0] shadow_mem [sle_pkg::CAPACITY];
	int                 shadow_cnt = 0;

	sle_pkg::req_t word_q [$];
	sle_pkg::rsp_t want_q [$];

	int errors    = 0;
	int cycles    = 0;
	int words_in  = 0;
	int words_out = 0;
	int full_hits = 0;

	int drv_gap   = 0;
	int drv_calm  = 0;
	int drv_draw;
	int mon_hold  = 0;
	int mon_calm  = 0;
	int mon_draw;
	sle_pkg::rsp_t exp_word;

	sorted_list_engine_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// shadow store
	// ------------------------------------------------------------------
	function automatic sle_pkg::rsp_t make_rsp(logic [1:0] st, logic fnd,
			logic signed [31:0] el, logic lst);
		sle_pkg::rsp_t r;
		r.status    = st;
		r.found     = fnd;
		r.element   = el;
		r.occupancy = shadow_cnt[sle_pkg::OCC_W-1:0];
		r.last      = lst;
		return r;
	endfunction

	function automatic int locate(logic signed [31:0] v);
		for (int i = 0; i < shadow_cnt; i++) begin
			if (shadow_mem[i] == v)
				return i;
		end
		return shadow_cnt;
	endfunction

	task automatic drop_at(int pos);
		for (int i = pos; i + 1 < shadow_cnt; i++)
			shadow_mem[i] = shadow_mem[i + 1];
		shadow_cnt--;
	endtask

	task automatic apply_word(sle_pkg::req_t w);
		int pos;
		logic signed [31:0] head;
		case (w.opcode)
			sle_pkg::OP_INSERT: begin
				if (shadow_cnt >= sle_pkg::CAPACITY) begin
					full_hits++;
					want_q.push_back(make_rsp(sle_pkg::ST_FULL, 1'b0, '0, 1'b1));
				end else begin
					pos = 0;
					while (pos < shadow_cnt && shadow_mem[pos] < w.value)
						pos++;
					for (int i = shadow_cnt; i > pos; i--)
						shadow_mem[i] = shadow_mem[i - 1];
					shadow_mem[pos] = w.value;
					shadow_cnt++;
					want_q.push_back(make_rsp(sle_pkg::ST_OK, 1'b0, '0, 1'b1));
				end
			end
			sle_pkg::OP_SEARCH: begin
				if (locate(w.value) < shadow_cnt)
					want_q.push_back(make_rsp(sle_pkg::ST_OK, 1'b1, '0, 1'b1));
				else
					want_q.push_back(make_rsp(sle_pkg::ST_NOT_FOUND, 1'b0, '0, 1'b1));
			end
			sle_pkg::OP_DELETE: begin
				pos = locate(w.value);
				if (shadow_cnt == 0) begin
					want_q.push_back(make_rsp(sle_pkg::ST_EMPTY, 1'b0, '0, 1'b1));
				end else if (pos >= shadow_cnt) begin
					want_q.push_back(make_rsp(sle_pkg::ST_NOT_FOUND, 1'b0, '0, 1'b1));
				end else begin
					drop_at(pos);
					want_q.push_back(make_rsp(sle_pkg::ST_OK, 1'b1, '0, 1'b1));
				end
			end
			sle_pkg::OP_POP: begin
				if (shadow_cnt == 0) begin
					want_q.push_back(make_rsp(sle_pkg::ST_EMPTY, 1'b0, '0, 1'b1));
				end else begin
					head = shadow_mem[0];
					drop_at(0);
					want_q.push_back(make_rsp(sle_pkg::ST_OK, 1'b0, head, 1'b1));
				end
			end
			sle_pkg::OP_DUMP: begin
				if (shadow_cnt == 0) begin
					want_q.push_back(make_rsp(sle_pkg::ST_EMPTY, 1'b0, '0, 1'b1));
				end else begin
					for (int i = 0; i < shadow_cnt; i++)
						want_q.push_back(make_rsp(sle_pkg::ST_OK, 1'b0, shadow_mem[i],
							i == shadow_cnt - 1));
				end
			end
			default: begin
				want_q.push_back(make_rsp(sle_pkg::ST_OK, 1'b0, '0, 1'b1));
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	function automatic int pick_wait(inout int calm);
		int n;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		n = $urandom_range(0, WAIT_MAX);
		if ($urandom_range(0, 24) == 0)
			calm = $urandom_range(8, 40);
		return n;
	endfunction

	function automatic logic signed [31:0] rand_val();
		case ($urandom_range(0, 9))
			0: return 32'sh8000_0000;
			1: return 32'sh7FFF_FFFF;
			2, 3, 4: return $signed($urandom_range(0, 8)) - 4;
			default: return $urandom;
		endcase
	endfunction

	task automatic push_word(logic [2:0] op, logic signed [31:0] v);
		sle_pkg::req_t w;
		w.opcode = op;
		w.value  = v;
		word_q.push_back(w);
	endtask

	task automatic build_stimulus();
		logic signed [31:0] seen [$];
		logic signed [31:0] v;
		int fill;
		int pick;
		// empty store corners, ignored opcodes
		push_word(sle_pkg::OP_DUMP, 32'sd0);
		push_word(sle_pkg::OP_POP, 32'sh7FFF_FFFF);
		push_word(sle_pkg::OP_DELETE, 32'sd7);
		push_word(sle_pkg::OP_SEARCH, 32'sd7);
		push_word(OP_RSVD5, 32'sh8000_0000);
		push_word(OP_RSVD6, 32'sh7FFF_FFFF);
		push_word(OP_RSVD7, -32'sd1);
		// extremes and a duplicate
		push_word(sle_pkg::OP_INSERT, 32'sh7FFF_FFFF);
		push_word(sle_pkg::OP_INSERT, 32'sh8000_0000);
		push_word(sle_pkg::OP_INSERT, 32'sd0);
		push_word(sle_pkg::OP_INSERT, 32'sd0);
		push_word(sle_pkg::OP_INSERT, -32'sd1);
		push_word(sle_pkg::OP_SEARCH, 32'sh7FFF_FFFF);
		push_word(sle_pkg::OP_SEARCH, 32'sd42);
		push_word(sle_pkg::OP_DELETE, 32'sd42);
		push_word(sle_pkg::OP_DELETE, 32'sd0);
		push_word(sle_pkg::OP_DUMP, 32'sd0);
		push_word(sle_pkg::OP_POP, 32'sd0);
		push_word(OP_RSVD5, 32'sd0);

		// each round drains to empty, refills (first round past full), then mixes
		for (int r = 0; r < ROUNDS; r++) begin
			seen.delete();
			repeat (DRAIN_CT) push_word(sle_pkg::OP_POP, $urandom);
			fill = (r == 0) ? sle_pkg::CAPACITY + 2
				: $urandom_range(3, sle_pkg::CAPACITY + 2);
			repeat (fill) begin
				v = rand_val();
				seen.push_back(v);
				push_word(sle_pkg::OP_INSERT, v);
			end
			push_word(sle_pkg::OP_DUMP, $urandom);
			repeat (28) begin
				pick = $urandom_range(0, 19);
				if (seen.size() != 0 && $urandom_range(0, 3) != 0)
					v = seen[$urandom_range(0, seen.size() - 1)];
				else
					v = rand_val();
				if (pick < 6 || pick == 19) begin
					seen.push_back(v);
					push_word(sle_pkg::OP_INSERT, v);
				end else if (pick < 10) begin
					push_word(sle_pkg::OP_SEARCH, v);
				end else if (pick < 14) begin
					push_word(sle_pkg::OP_DELETE, v);
				end else if (pick < 16) begin
					push_word(sle_pkg::OP_POP, v);
				end else if (pick < 18) begin
					push_word(sle_pkg::OP_DUMP, v);
				end else begin
					push_word(3'(OP_RSVD5 + $urandom_range(0, 2)), v);
				end
			end
			push_word(sle_pkg::OP_DUMP, $urandom);
		end
	endtask

	// ------------------------------------------------------------------
	// driver
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
			drv_gap   <= 0;
		end else begin
			if (req_valid && !req_stall) begin
				apply_word(req);
				words_in++;
				drv_draw = pick_wait(drv_calm);
				if (drv_draw == 0 && word_q.size() != 0)
					req <= word_q.pop_front();
				else
					req_valid <= 1'b0;
				drv_gap <= drv_draw;
			end else if (!req_valid) begin
				if (drv_gap > 0) begin
					drv_gap <= drv_gap - 1;
				end else if (word_q.size() != 0) begin
					req       <= word_q.pop_front();
					req_valid <= 1'b1;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			mon_hold  <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				words_out++;
				if (want_q.size() == 0) begin
					$error("result word with nothing expected: %p", rsp);
					errors++;
				end else begin
					exp_word = want_q.pop_front();
					if (rsp.status !== exp_word.status) begin
						$error("status: expected %0d actual %0d", exp_word.status, rsp.status);
						errors++;
					end
					if (rsp.found !== exp_word.found) begin
						$error("found: expected %0d actual %0d", exp_word.found, rsp.found);
						errors++;
					end
					if (rsp.element !== exp_word.element) begin
						$error("element: expected %0d actual %0d", exp_word.element,
							rsp.element);
						errors++;
					end
					if (rsp.occupancy !== exp_word.occupancy) begin
						$error("occupancy: expected %0d actual %0d", exp_word.occupancy,
							rsp.occupancy);
						errors++;
					end
					if (rsp.last !== exp_word.last) begin
						$error("last: expected %0d actual %0d", exp_word.last, rsp.last);
						errors++;
					end
				end
				mon_draw = pick_wait(mon_calm);
				rsp_stall <= (mon_draw != 0);
				mon_hold  <= mon_draw;
			end else if (mon_hold > 0) begin
				mon_hold <= mon_hold - 1;
				if (mon_hold == 1)
					rsp_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		build_stimulus();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		while (word_q.size() != 0 || req_valid)
			@(posedge clk);
		while (want_q.size() != 0)
			@(posedge clk);
		// extra time to catch any unexpected result words
		repeat (40) @(posedge clk);
		$display("run: %0d request words, %0d result words, %0d full rejections",
			words_in, words_out, full_hits);
		$display("run: %0d mismatches over %0d cycles", errors, cycles);
		if (errors == 0 && want_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
